/* rtl/sparse_triplet_to_compressed_builder_defines.svh */
// ----------------------------------------------------------------------------
// sparse triplet builder assertion macros
// shared concurrent assertion forms, clocked on clock, quiet during reset
// ----------------------------------------------------------------------------
`ifndef SPARSE_TRIPLET_TO_COMPRESSED_BUILDER_DEFINES_SVH
`define SPARSE_TRIPLET_TO_COMPRESSED_BUILDER_DEFINES_SVH

// same-cycle implication
`define STCB_ASSERT_NOW(label, cond, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error(msg);

// next-cycle implication
`define STCB_ASSERT_NEXT(label, cond, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error(msg);

`endif

/* rtl/stcb_pkg.sv */
// ----------------------------------------------------------------------------
// stcb_pkg
// shared widths, codes and controller/datapath interface types
// ----------------------------------------------------------------------------
`default_nettype none

package stcb_pkg;

   localparam int OP_W   = 3;
   localparam int ST_W   = 2;
   localparam int IDX_W  = 10;
   localparam int POS_W  = 11;
   localparam int VAL_W  = 32;
   localparam int SUM_W  = 48;
   localparam int KEY_W  = 2 * IDX_W;
   localparam int CSR_AW = 2;

   // operation codes
   localparam logic [OP_W-1:0] OP_ADD    = 3'd0;
   localparam logic [OP_W-1:0] OP_BUILD  = 3'd1;
   localparam logic [OP_W-1:0] OP_PTR    = 3'd2;
   localparam logic [OP_W-1:0] OP_ENTRY  = 3'd3;
   localparam logic [OP_W-1:0] OP_LOOKUP = 3'd4;

   // status codes
   localparam logic [ST_W-1:0] ST_OK        = 2'd0;
   localparam logic [ST_W-1:0] ST_FULL      = 2'd1;
   localparam logic [ST_W-1:0] ST_RANGE     = 2'd2;
   localparam logic [ST_W-1:0] ST_NOT_BUILT = 2'd3;

   // register indexes
   localparam logic [CSR_AW-1:0] CSR_ROW_TOTAL    = 2'd0;
   localparam logic [CSR_AW-1:0] CSR_COLUMN_TOTAL = 2'd1;
   localparam logic [CSR_AW-1:0] CSR_ROW_MAJOR    = 2'd2;

   // saturation bounds of the duplicate sum
   localparam logic signed [SUM_W-1:0] SAT_HI = 48'sh0000_7FFF_FFFF;
   localparam logic signed [SUM_W-1:0] SAT_LO = 48'shFFFF_8000_0000;

   typedef struct packed {
      logic            load_req;
      logic            add_write;
      logic            status_set;
      logic [ST_W-1:0] status_code;
      logic            ptr_rd_pos;
      logic            ent_rd_pos;
      logic            ptr_rd_maj;
      logic            take_lo;
      logic            take_hi;
      logic            srch_issue_mid;
      logic            srch_update;
      logic            take_ptr_word;
      logic            take_entry;
      logic            take_lookup;
      logic            b_init;
      logic            scan_step;
      logic            fill_write;
      logic            emit;
      logic            b_finish;
      logic            rsp_load;
   } cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            full;
      logic            built;
      logic            ptr_oob;
      logic            ent_oob;
      logic            lk_oob;
      logic            scan_done;
      logic            found;
      logic            fill_done;
      logic            srch_more;
   } sts_type;

endpackage

`default_nettype wire

/* rtl/stcb_ram.sv */
// ----------------------------------------------------------------------------
// stcb_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module stcb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

/* rtl/stcb_ctrl.sv */
// ----------------------------------------------------------------------------
// stcb_ctrl
// sequencer for add, build, reads and lookup; drives datapath commands
// ----------------------------------------------------------------------------
`default_nettype none

module stcb_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output      logic             req_stall,
   output      logic             rsp_valid,
   input  wire logic             rsp_stall,
   input  wire stcb_pkg::sts_type sts,
   output      stcb_pkg::cmd_type cmd
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DISP   = 4'd1;
   localparam logic [3:0] S_DONE   = 4'd2;
   localparam logic [3:0] S_B_SCAN = 4'd3;
   localparam logic [3:0] S_B_FILL = 4'd4;
   localparam logic [3:0] S_B_EMIT = 4'd5;
   localparam logic [3:0] S_B_END  = 4'd6;
   localparam logic [3:0] S_RD_P   = 4'd7;
   localparam logic [3:0] S_RD_E   = 4'd8;
   localparam logic [3:0] S_L_P1   = 4'd9;
   localparam logic [3:0] S_L_P2   = 4'd10;
   localparam logic [3:0] S_L_LOOP = 4'd11;
   localparam logic [3:0] S_L_CMP  = 4'd12;
   localparam logic [3:0] S_L_FIN  = 4'd13;

   logic [3:0] state_ff;
   logic [3:0] state_in;
   logic       rsp_valid_ff;

   // no item is taken while in reset
   assign req_stall = reset || (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // next state and commands
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_DISP;
            end
         end
         S_DISP: begin
            priority if (sts.op == stcb_pkg::OP_ADD) begin
               cmd.add_write   = !sts.full;
               cmd.status_set  = sts.full;
               cmd.status_code = stcb_pkg::ST_FULL;
               state_in        = S_DONE;
            end else if (sts.op == stcb_pkg::OP_BUILD) begin
               cmd.b_init = 1'b1;
               state_in   = S_B_SCAN;
            end else if (sts.op > stcb_pkg::OP_LOOKUP) begin
               state_in = S_IDLE;
            end else if (!sts.built) begin
               cmd.status_set  = 1'b1;
               cmd.status_code = stcb_pkg::ST_NOT_BUILT;
               state_in        = S_DONE;
            end else if (sts.op == stcb_pkg::OP_PTR) begin
               cmd.status_set  = sts.ptr_oob;
               cmd.status_code = stcb_pkg::ST_RANGE;
               cmd.ptr_rd_pos  = 1'b1;
               state_in        = sts.ptr_oob ? S_DONE : S_RD_P;
            end else if (sts.op == stcb_pkg::OP_ENTRY) begin
               cmd.status_set  = sts.ent_oob;
               cmd.status_code = stcb_pkg::ST_RANGE;
               cmd.ent_rd_pos  = 1'b1;
               state_in        = sts.ent_oob ? S_DONE : S_RD_E;
            end else begin
               cmd.status_set  = sts.lk_oob;
               cmd.status_code = stcb_pkg::ST_RANGE;
               cmd.ptr_rd_maj  = 1'b1;
               state_in        = sts.lk_oob ? S_DONE : S_L_P1;
            end
         end
         S_RD_P: begin
            cmd.take_ptr_word = 1'b1;
            state_in          = S_DONE;
         end
         S_RD_E: begin
            cmd.take_entry = 1'b1;
            state_in       = S_DONE;
         end
         S_L_P1: begin
            cmd.take_lo = 1'b1;
            state_in    = S_L_P2;
         end
         S_L_P2: begin
            cmd.take_hi = 1'b1;
            state_in    = S_L_LOOP;
         end
         S_L_LOOP: begin
            if (sts.srch_more) begin
               cmd.srch_issue_mid = 1'b1;
               state_in           = S_L_CMP;
            end else begin
               state_in = S_L_FIN;
            end
         end
         S_L_CMP: begin
            cmd.srch_update = 1'b1;
            state_in        = S_L_LOOP;
         end
         S_L_FIN: begin
            cmd.take_lookup = 1'b1;
            state_in        = S_DONE;
         end
         S_B_SCAN: begin
            if (sts.scan_done) begin
               state_in = S_B_FILL;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         S_B_FILL: begin
            if (!sts.fill_done) begin
               cmd.fill_write = 1'b1;
            end else begin
               state_in = sts.found ? S_B_EMIT : S_B_END;
            end
         end
         S_B_EMIT: begin
            cmd.emit = 1'b1;
            state_in = S_B_SCAN;
         end
         S_B_END: begin
            cmd.b_finish = 1'b1;
            state_in     = S_DONE;
         end
         S_DONE: begin
            if (!(rsp_valid_ff && rsp_stall)) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule

`default_nettype wire

/* rtl/stcb_dp.sv */
// ----------------------------------------------------------------------------
// stcb_dp
// registers, stores, build scan, binary search and result registers
// ----------------------------------------------------------------------------
`default_nettype none

module stcb_dp #(
   parameter int MAX_TRIPLETS  = 1024,
   parameter int MAX_DIMENSION = 1024
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_write,
   input  wire logic [stcb_pkg::CSR_AW-1:0]         csr_index,
   input  wire logic [stcb_pkg::POS_W-1:0]          csr_data,
   input  wire logic [stcb_pkg::OP_W-1:0]           req_operation,
   input  wire logic [stcb_pkg::IDX_W-1:0]          req_row_index,
   input  wire logic [stcb_pkg::IDX_W-1:0]          req_column_index,
   input  wire logic signed [stcb_pkg::VAL_W-1:0]   req_entry_value,
   input  wire logic [stcb_pkg::POS_W-1:0]          req_read_position,
   input  wire stcb_pkg::cmd_type                   cmd,
   output      stcb_pkg::sts_type                   sts,
   output      logic [stcb_pkg::ST_W-1:0]           rsp_status,
   output      logic signed [stcb_pkg::VAL_W-1:0]   rsp_result_value,
   output      logic [stcb_pkg::IDX_W-1:0]          rsp_minor_position,
   output      logic [stcb_pkg::POS_W-1:0]          rsp_pointer_word
);

   localparam int IDX_W = stcb_pkg::IDX_W;
   localparam int VAL_W = stcb_pkg::VAL_W;
   localparam int POS_W = stcb_pkg::POS_W;
   localparam int KEY_W = stcb_pkg::KEY_W;
   localparam int SUM_W = stcb_pkg::SUM_W;
   localparam int TA_W  = $clog2(MAX_TRIPLETS);
   localparam int CNT_W = $clog2(MAX_TRIPLETS + 1);
   localparam int PD    = MAX_DIMENSION + 1;
   localparam int PA_W  = $clog2(PD);
   localparam int PW    = $clog2(MAX_DIMENSION + 2);
   localparam int TW    = 2 * IDX_W + VAL_W;
   localparam int EW    = IDX_W + VAL_W;

   // configuration
   logic [POS_W-1:0] row_total_ff;
   logic [POS_W-1:0] column_total_ff;
   logic             mode_ff;

   // latched item
   logic [stcb_pkg::OP_W-1:0] op_ff;
   logic [IDX_W-1:0]          row_ff;
   logic [IDX_W-1:0]          col_ff;
   logic signed [VAL_W-1:0]   val_ff;
   logic [POS_W-1:0]          pos_ff;

   // persistent state
   logic [CNT_W-1:0] count_ff;
   logic             built_ff;
   logic [CNT_W-1:0] stored_ff;
   logic [PA_W-1:0]  bmaj_ff;
   logic             brow_ff;

   // build state
   logic                    bm_ff;
   logic [PA_W-1:0]         majors_ff;
   logic [CNT_W-1:0]        scan_i_ff;
   logic                    pipe_ff;
   logic                    found_ff;
   logic                    first_ff;
   logic [KEY_W-1:0]        best_ff;
   logic [KEY_W-1:0]        last_ff;
   logic signed [SUM_W-1:0] sum_ff;
   logic [CNT_W-1:0]        cnt_ff;
   logic [PW-1:0]           p_ff;

   // search state
   logic [CNT_W-1:0] lo_ff;
   logic [CNT_W-1:0] hi_ff;
   logic [CNT_W-1:0] end_ff;
   logic [CNT_W-1:0] mid_ff;
   logic [CNT_W-1:0] mid_in;

   // result staging and output
   logic [stcb_pkg::ST_W-1:0] res_status_ff;
   logic signed [VAL_W-1:0]   res_value_ff;
   logic [IDX_W-1:0]          res_minor_ff;
   logic [POS_W-1:0]          res_word_ff;
   logic [stcb_pkg::ST_W-1:0] rsp_status_ff;
   logic signed [VAL_W-1:0]   rsp_value_ff;
   logic [IDX_W-1:0]          rsp_minor_ff;
   logic [POS_W-1:0]          rsp_word_ff;

   // memory ports
   logic [TW-1:0]    trip_rd;
   logic [TA_W-1:0]  trip_rd_addr;
   logic [EW-1:0]    ent_rd;
   logic [EW-1:0]    ent_wr_data;
   logic [TA_W-1:0]  ent_rd_addr;
   logic [CNT_W-1:0] ptr_rd;
   logic [PA_W-1:0]  ptr_rd_addr;
   logic [PA_W-1:0]  ptr_wr_addr;
   logic [CNT_W-1:0] ptr_wr_data;

   // decoded values
   logic [IDX_W-1:0]        t_row;
   logic [IDX_W-1:0]        t_col;
   logic signed [VAL_W-1:0] t_val;
   logic [IDX_W-1:0]        t_maj;
   logic [IDX_W-1:0]        t_mnr;
   logic [KEY_W-1:0]        t_key;
   logic                    t_elig;
   logic [IDX_W-1:0]        lk_maj;
   logic [IDX_W-1:0]        lk_mnr;
   logic [POS_W-1:0]        lk_maj1;
   logic [IDX_W-1:0]        e_minor;
   logic signed [VAL_W-1:0] e_val;
   logic signed [VAL_W-1:0] sat_val;
   logic [POS_W-1:0]        sel_total;
   logic [PA_W-1:0]         majors_in;
   logic [PW-1:0]           fill_tgt;

   assign t_row  = trip_rd[TW-1 -: IDX_W];
   assign t_col  = trip_rd[VAL_W +: IDX_W];
   assign t_val  = trip_rd[VAL_W-1:0];
   assign t_maj  = bm_ff ? t_row : t_col;
   assign t_mnr  = bm_ff ? t_col : t_row;
   assign t_key  = {t_maj, t_mnr};
   assign t_elig = pipe_ff && (32'(t_maj) < 32'(majors_ff))
                   && (first_ff || (t_key > last_ff));

   assign lk_maj  = brow_ff ? row_ff : col_ff;
   assign lk_mnr  = brow_ff ? col_ff : row_ff;
   assign lk_maj1 = POS_W'(lk_maj) + POS_W'(1);
   assign e_minor = ent_rd[EW-1 -: IDX_W];
   assign e_val   = ent_rd[VAL_W-1:0];
   assign mid_in  = lo_ff + ((hi_ff - lo_ff) >> 1);

   // saturate the exact duplicate sum
   always_comb begin
      if (sum_ff > stcb_pkg::SAT_HI) begin
         sat_val = stcb_pkg::SAT_HI[VAL_W-1:0];
      end else if (sum_ff < stcb_pkg::SAT_LO) begin
         sat_val = stcb_pkg::SAT_LO[VAL_W-1:0];
      end else begin
         sat_val = sum_ff[VAL_W-1:0];
      end
   end

   // major size of a build, capped at MAX_DIMENSION, one below the pointer store depth
   assign sel_total = mode_ff ? row_total_ff : column_total_ff;
   assign majors_in = (32'(sel_total) > MAX_DIMENSION) ? PA_W'(MAX_DIMENSION)
                                                        : PA_W'(sel_total);
   assign fill_tgt  = found_ff ? PW'(best_ff[KEY_W-1 -: IDX_W]) : PW'(majors_ff);

   // status to the controller
   always_comb begin
      sts.op        = op_ff;
      sts.full      = (count_ff >= CNT_W'(MAX_TRIPLETS));
      sts.built     = built_ff;
      sts.ptr_oob   = (32'(pos_ff) > 32'(bmaj_ff));
      sts.ent_oob   = (32'(pos_ff) >= 32'(stored_ff));
      sts.lk_oob    = (32'(lk_maj) >= 32'(bmaj_ff));
      sts.scan_done = !(scan_i_ff < count_ff) && !pipe_ff;
      sts.found     = found_ff;
      sts.fill_done = (p_ff > fill_tgt);
      sts.srch_more = (lo_ff < hi_ff);
   end

   // read address selection
   always_comb begin
      trip_rd_addr = TA_W'(scan_i_ff);
      if (cmd.ptr_rd_pos) begin
         ptr_rd_addr = PA_W'(pos_ff);
      end else if (cmd.ptr_rd_maj) begin
         ptr_rd_addr = PA_W'(lk_maj);
      end else begin
         ptr_rd_addr = PA_W'(lk_maj1);
      end
      if (cmd.ent_rd_pos) begin
         ent_rd_addr = TA_W'(pos_ff);
      end else if (cmd.srch_issue_mid) begin
         ent_rd_addr = TA_W'(mid_in);
      end else begin
         ent_rd_addr = TA_W'(lo_ff);
      end
      ptr_wr_addr = cmd.b_init ? PA_W'(0) : PA_W'(p_ff);
      ptr_wr_data = cmd.b_init ? CNT_W'(0) : cnt_ff;
      ent_wr_data = {best_ff[IDX_W-1:0], sat_val};
   end

   stcb_ram #(.WIDTH(TW), .DEPTH(MAX_TRIPLETS)) u_trip_ram (
      .clock   (clock),
      .wr_en   (cmd.add_write),
      .wr_addr (TA_W'(count_ff)),
      .wr_data ({row_ff, col_ff, val_ff}),
      .rd_addr (trip_rd_addr),
      .rd_data (trip_rd)
   );

   stcb_ram #(.WIDTH(EW), .DEPTH(MAX_TRIPLETS)) u_ent_ram (
      .clock   (clock),
      .wr_en   (cmd.emit && (sum_ff != '0)),
      .wr_addr (TA_W'(cnt_ff)),
      .wr_data (ent_wr_data),
      .rd_addr (ent_rd_addr),
      .rd_data (ent_rd)
   );

   stcb_ram #(.WIDTH(CNT_W), .DEPTH(PD)) u_ptr_ram (
      .clock   (clock),
      .wr_en   (cmd.b_init || cmd.fill_write),
      .wr_addr (ptr_wr_addr),
      .wr_data (ptr_wr_data),
      .rd_addr (ptr_rd_addr),
      .rd_data (ptr_rd)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         row_total_ff    <= POS_W'(1024);
         column_total_ff <= POS_W'(1024);
         mode_ff         <= 1'b1;
         count_ff        <= '0;
         built_ff        <= 1'b0;
         stored_ff       <= '0;
         bmaj_ff         <= '0;
         brow_ff         <= 1'b0;
         pipe_ff         <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               stcb_pkg::CSR_ROW_TOTAL:    row_total_ff    <= csr_data;
               stcb_pkg::CSR_COLUMN_TOTAL: column_total_ff <= csr_data;
               stcb_pkg::CSR_ROW_MAJOR:    mode_ff         <= csr_data[0];
               default: ;
            endcase
         end
         if (cmd.add_write) begin
            count_ff <= count_ff + CNT_W'(1);
         end
         if (cmd.b_init || cmd.emit) begin
            pipe_ff <= 1'b0;
         end else if (cmd.scan_step) begin
            pipe_ff <= (scan_i_ff < count_ff);
         end
         if (cmd.b_finish) begin
            built_ff  <= 1'b1;
            stored_ff <= cnt_ff;
            bmaj_ff   <= majors_ff;
            brow_ff   <= bm_ff;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff         <= req_operation;
         row_ff        <= req_row_index;
         col_ff        <= req_column_index;
         val_ff        <= req_entry_value;
         pos_ff        <= req_read_position;
         res_status_ff <= stcb_pkg::ST_OK;
         res_value_ff  <= '0;
         res_minor_ff  <= '0;
         res_word_ff   <= '0;
      end
      if (cmd.status_set) begin
         res_status_ff <= cmd.status_code;
      end

      // build: scan for the smallest key above the last one emitted
      if (cmd.b_init) begin
         bm_ff     <= mode_ff;
         majors_ff <= majors_in;
         cnt_ff    <= '0;
         p_ff      <= PW'(1);
         first_ff  <= 1'b1;
      end
      if (cmd.b_init || cmd.emit) begin
         scan_i_ff <= '0;
         found_ff  <= 1'b0;
      end
      if (cmd.scan_step) begin
         if (scan_i_ff < count_ff) begin
            scan_i_ff <= scan_i_ff + CNT_W'(1);
         end
         if (t_elig) begin
            if (!found_ff || (t_key < best_ff)) begin
               best_ff  <= t_key;
               sum_ff   <= SUM_W'(t_val);
               found_ff <= 1'b1;
            end else if (t_key == best_ff) begin
               sum_ff <= sum_ff + SUM_W'(t_val);
            end
         end
      end
      if (cmd.fill_write) begin
         p_ff <= p_ff + PW'(1);
      end
      if (cmd.emit) begin
         last_ff  <= best_ff;
         first_ff <= 1'b0;
         if (sum_ff != '0) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
         end
      end
      if (cmd.b_finish) begin
         res_word_ff <= POS_W'(cnt_ff);
      end

      // reads and binary search
      if (cmd.take_ptr_word) begin
         res_word_ff <= POS_W'(ptr_rd);
      end
      if (cmd.take_entry) begin
         res_value_ff <= e_val;
         res_minor_ff <= e_minor;
      end
      if (cmd.take_lo) begin
         lo_ff <= ptr_rd;
      end
      if (cmd.take_hi) begin
         hi_ff  <= ptr_rd;
         end_ff <= ptr_rd;
      end
      if (cmd.srch_issue_mid) begin
         mid_ff <= mid_in;
      end
      if (cmd.srch_update) begin
         if (e_minor < lk_mnr) begin
            lo_ff <= mid_ff + CNT_W'(1);
         end else begin
            hi_ff <= mid_ff;
         end
      end
      if (cmd.take_lookup && (lo_ff < end_ff) && (e_minor == lk_mnr)) begin
         res_value_ff <= e_val;
      end

      // output register
      if (cmd.rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_value_ff  <= res_value_ff;
         rsp_minor_ff  <= res_minor_ff;
         rsp_word_ff   <= res_word_ff;
      end
   end

   assign rsp_status         = rsp_status_ff;
   assign rsp_result_value   = rsp_value_ff;
   assign rsp_minor_position = rsp_minor_ff;
   assign rsp_pointer_word   = rsp_word_ff;

endmodule

`default_nettype wire

/* rtl/sparse_triplet_to_compressed_builder.sv */
// ----------------------------------------------------------------------------
// sparse_triplet_to_compressed_builder
// collects sparse triplets and builds a compressed row or column form
// ----------------------------------------------------------------------------
// usage:
//  - req_* carries one item per accept (valid high, stall low); the block
//    stalls the request side until the item's result is staged
//  - rsp_* returns one result per item; unknown operations give none
//  - csr_* writes row_total, column_total, row_major_mode; always ready
//  - add items pass the dispatch and done states to the output register;
//    pointer and entry reads add a read state; the next item is taken in idle
//  - a lookup reads both pointer words, then runs a binary search with one
//    registered entry store read in each search step
//  - a build runs one pass per distinct in-range key and one final pass:
//    each pass scans the triplet store once for the next key, then pointer
//    words are written one a cycle
//  - reset clears the triplet count and the built flag, and restores the
//    register defaults; no clearing pass is run
//  - if the receiver stalls, the result waits in the output register and
//    the next item is taken but not finished until the register frees
// ----------------------------------------------------------------------------
`default_nettype none

`include "sparse_triplet_to_compressed_builder_defines.svh"

module sparse_triplet_to_compressed_builder #(
   parameter int MAX_TRIPLETS  = 1024,
   parameter int MAX_DIMENSION = 1024
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_valid,
   output      logic                              csr_ready,
   input  wire logic [stcb_pkg::CSR_AW-1:0]       csr_index,
   input  wire logic [stcb_pkg::POS_W-1:0]        csr_data,
   input  wire logic                              req_valid,
   output      logic                              req_stall,
   input  wire logic [stcb_pkg::OP_W-1:0]         req_operation,
   input  wire logic [stcb_pkg::IDX_W-1:0]        req_row_index,
   input  wire logic [stcb_pkg::IDX_W-1:0]        req_column_index,
   input  wire logic signed [stcb_pkg::VAL_W-1:0] req_entry_value,
   input  wire logic [stcb_pkg::POS_W-1:0]        req_read_position,
   output      logic                              rsp_valid,
   input  wire logic                              rsp_stall,
   output      logic [stcb_pkg::ST_W-1:0]         rsp_status,
   output      logic signed [stcb_pkg::VAL_W-1:0] rsp_result_value,
   output      logic [stcb_pkg::IDX_W-1:0]        rsp_minor_position,
   output      logic [stcb_pkg::POS_W-1:0]        rsp_pointer_word
);

   stcb_pkg::cmd_type cmd;
   stcb_pkg::sts_type sts;

   assign csr_ready = 1'b1;

   stcb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   stcb_dp #(
      .MAX_TRIPLETS  (MAX_TRIPLETS),
      .MAX_DIMENSION (MAX_DIMENSION)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .csr_write          (csr_valid && csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .req_operation      (req_operation),
      .req_row_index      (req_row_index),
      .req_column_index   (req_column_index),
      .req_entry_value    (req_entry_value),
      .req_read_position  (req_read_position),
      .cmd                (cmd),
      .sts                (sts),
      .rsp_status         (rsp_status),
      .rsp_result_value   (rsp_result_value),
      .rsp_minor_position (rsp_minor_position),
      .rsp_pointer_word   (rsp_pointer_word)
   );

   // a staged result never overwrites one still waiting
   `STCB_ASSERT_NOW(a_rsp_slot_free, cmd.rsp_load, !(rsp_valid && rsp_stall), "result overwritten")
   // a finished build marks the store as built
   `STCB_ASSERT_NEXT(a_build_marks, cmd.b_finish, sts.built, "build flag not set")
   // a triplet is only stored while there is room
   `STCB_ASSERT_NOW(a_add_room, cmd.add_write, !sts.full, "triplet store overrun")

endmodule

`default_nettype wire

/* test/sparse_triplet_to_compressed_builder_tb.sv */
// ----------------------------------------------------------------------------
// sparse_triplet_to_compressed_builder_tb
// Loads triplets, builds compressed forms under several shapes and modes,
// then reads pointer words and entries and looks up values. Every result is
// checked against a shadow copy of the matrix kept in a scoreboard class.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module sparse_triplet_to_compressed_builder_tb;
   import stcb_pkg::*;

   localparam int STORE_DEPTH = 1024;
   localparam int DIM_LIMIT   = 1024;
   localparam int CYCLE_LIMIT = 12000000;
   localparam int SETTLE      = 40;
   localparam int PHASES      = 3;
   localparam logic [OP_W-1:0] OP_UNKNOWN_LO = 3'd5;
   localparam logic [OP_W-1:0] OP_UNKNOWN_HI = 3'd7;

   typedef struct {
      logic [ST_W-1:0]         status;
      logic signed [VAL_W-1:0] value;
      logic [IDX_W-1:0]        minor;
      logic [POS_W-1:0]        word;
   } result_type;

   // shadow of the triplet store and the compressed form
   class matrix_scoreboard;
      int unsigned row_total = 1024, column_total = 1024;
      bit          row_mode = 1;
      logic [IDX_W-1:0]        trip_row[STORE_DEPTH], trip_col[STORE_DEPTH];
      logic signed [VAL_W-1:0] trip_val[STORE_DEPTH];
      int unsigned             trip_count = 0;
      logic [IDX_W-1:0]        ent_minor[STORE_DEPTH];
      logic signed [VAL_W-1:0] ent_val[STORE_DEPTH];
      int unsigned             ptrs[DIM_LIMIT+1];
      bit                      built = 0;
      int unsigned             ent_count = 0, built_majors = 0;
      bit                      built_row = 0;
      result_type              awaited[$];
      int                      errors = 0;

      function void write_reg(logic [CSR_AW-1:0] idx, logic [POS_W-1:0] data);
         case (idx)
            CSR_ROW_TOTAL:    row_total = 32'(data);
            CSR_COLUMN_TOTAL: column_total = 32'(data);
            CSR_ROW_MAJOR:    row_mode = data[0];
            default: ;
         endcase
      endfunction

      function void compress();
         int unsigned keys[STORE_DEPTH];
         longint      vals[STORE_DEPTH];
         int unsigned tk, j, k, m, cnt, majors, key;
         longint      tv, sum;
         for (int unsigned i = 0; i < trip_count; i++) begin
            tk = row_mode ? 32'({trip_row[i], 6'd0, trip_col[i]})
                          : 32'({trip_col[i], 6'd0, trip_row[i]});
            tv = trip_val[i];
            j = i;
            while (j > 0 && keys[j-1] > tk) begin
               keys[j] = keys[j-1];
               vals[j] = vals[j-1];
               j--;
            end
            keys[j] = tk;
            vals[j] = tv;
         end
         majors = row_mode ? row_total : column_total;
         if (majors > DIM_LIMIT) majors = DIM_LIMIT;
         k = 0;
         cnt = 0;
         ptrs[0] = 0;
         for (m = 0; m < majors; m++) begin
            while (k < trip_count && (keys[k] >> 16) == m) begin
               key = keys[k];
               sum = 0;
               while (k < trip_count && keys[k] == key) begin
                  sum += vals[k];
                  k++;
               end
               if (sum != 0 && cnt < STORE_DEPTH) begin
                  if (sum > 64'sh7FFF_FFFF) sum = 64'sh7FFF_FFFF;
                  if (sum < -64'sh8000_0000) sum = -64'sh8000_0000;
                  ent_minor[cnt] = key[IDX_W-1:0];
                  ent_val[cnt] = sum[VAL_W-1:0];
                  cnt++;
               end
            end
            ptrs[m+1] = cnt;
         end
         ent_count = cnt;
         built_majors = majors;
         built_row = row_mode;
         built = 1;
      endfunction

      // note one accepted item and queue its expected result
      function void take_item(logic [OP_W-1:0] op, logic [IDX_W-1:0] row,
                              logic [IDX_W-1:0] col, logic signed [VAL_W-1:0] val,
                              logic [POS_W-1:0] pos);
         result_type  r;
         int unsigned maj, mnr, lo, hi, mid;
         r = '{ST_OK, '0, '0, '0};
         if (op >= OP_UNKNOWN_LO) return;
         if (op == OP_ADD) begin
            if (trip_count >= STORE_DEPTH) r.status = ST_FULL;
            else begin
               trip_row[trip_count] = row;
               trip_col[trip_count] = col;
               trip_val[trip_count] = val;
               trip_count++;
            end
         end else if (op == OP_BUILD) begin
            compress();
            r.word = POS_W'(ent_count);
         end else if (!built) r.status = ST_NOT_BUILT;
         else if (op == OP_PTR) begin
            if (pos > built_majors) r.status = ST_RANGE;
            else r.word = POS_W'(ptrs[pos]);
         end else if (op == OP_ENTRY) begin
            if (pos >= ent_count) r.status = ST_RANGE;
            else begin
               r.value = ent_val[pos];
               r.minor = ent_minor[pos];
            end
         end else begin
            maj = built_row ? 32'(row) : 32'(col);
            mnr = built_row ? 32'(col) : 32'(row);
            if (maj >= built_majors) r.status = ST_RANGE;
            else begin
               lo = ptrs[maj];
               hi = ptrs[maj+1];
               while (lo < hi) begin
                  mid = lo + (hi - lo) / 2;
                  if (ent_minor[mid] < mnr) lo = mid + 1;
                  else hi = mid;
               end
               if (lo < ptrs[maj+1] && ent_minor[lo] == mnr) r.value = ent_val[lo];
            end
         end
         awaited = {awaited, r};
      endfunction

      function void check_result(result_type got);
         result_type exp_r;
         if (awaited.size() == 0) begin
            $display("%0t: unexpected result, status %0d value %h", $time,
                     got.status, got.value);
            errors++;
            return;
         end
         exp_r = awaited.pop_front();
         if (got.status !== exp_r.status) begin
            $display("%0t: status expected %0d actual %0d", $time, exp_r.status, got.status);
            errors++;
         end
         if (got.value !== exp_r.value) begin
            $display("%0t: value expected %h actual %h", $time, exp_r.value, got.value);
            errors++;
         end
         if (got.minor !== exp_r.minor) begin
            $display("%0t: minor expected %0d actual %0d", $time, exp_r.minor, got.minor);
            errors++;
         end
         if (got.word !== exp_r.word) begin
            $display("%0t: word expected %0d actual %0d", $time, exp_r.word, got.word);
            errors++;
         end
      endfunction
   endclass

   logic                    clock = 0;
   logic                    reset = 1;
   logic                    csr_valid = 0;
   logic                    csr_ready;
   logic [CSR_AW-1:0]       csr_index = '0;
   logic [POS_W-1:0]        csr_data = '0;
   logic                    req_valid = 0;
   logic                    req_stall;
   logic [OP_W-1:0]         req_operation = OP_ADD;
   logic [IDX_W-1:0]        req_row_index = '0;
   logic [IDX_W-1:0]        req_column_index = '0;
   logic signed [VAL_W-1:0] req_entry_value = '0;
   logic [POS_W-1:0]        req_read_position = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 0;
   logic [ST_W-1:0]         rsp_status;
   logic signed [VAL_W-1:0] rsp_result_value;
   logic [IDX_W-1:0]        rsp_minor_position;
   logic [POS_W-1:0]        rsp_pointer_word;

   matrix_scoreboard sb = new();
   bit               quiet = 0;
   int unsigned      cycles = 0;
   int unsigned      adds_sent = 0;

   sparse_triplet_to_compressed_builder u_dut (.*);

   always #4 clock = ~clock;

   // cycle limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // receiver stalls
   always @(posedge clock) begin
      rsp_stall <= !quiet && ($urandom_range(0, 99) < 10);
   end

   // input monitor
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         sb.take_item(req_operation, req_row_index, req_column_index,
                      req_entry_value, req_read_position);
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result('{rsp_status, rsp_result_value, rsp_minor_position,
                           rsp_pointer_word});
   end

   task automatic send(logic [OP_W-1:0] op, logic [IDX_W-1:0] row,
                       logic [IDX_W-1:0] col, logic signed [VAL_W-1:0] val,
                       logic [POS_W-1:0] pos);
      if (!quiet && $urandom_range(0, 99) < 10) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1;
      req_operation <= op;
      req_row_index <= row;
      req_column_index <= col;
      req_entry_value <= val;
      req_read_position <= pos;
      if (op == OP_ADD) adds_sent++;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (sb.awaited.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_AW-1:0] idx, logic [POS_W-1:0] data);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_reg(idx, data);
      csr_valid <= 0;
      @(posedge clock);
   endtask

   function automatic logic [IDX_W-1:0] pick_index(int wide_pct);
      if ($urandom_range(0, 99) < wide_pct) return IDX_W'($urandom_range(0, 1023));
      return IDX_W'($urandom_range(0, 3));
   endfunction

   function automatic logic signed [VAL_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 32'sh7FFF_FFFF;
         1: return 32'sh8000_0000;
         2: return 32'sh0001_0000;
         3: return -32'sh0001_0000;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [POS_W-1:0] pick_position();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 50) return POS_W'($urandom_range(0, 12));
      if (r < 90) return POS_W'($urandom_range(0, sb.ent_count + 2));
      return POS_W'($urandom_range(0, 1024));
   endfunction

   // one random item; adds only when allowed
   task automatic random_item(bit with_adds);
      int unsigned r;
      r = $urandom_range(with_adds ? 0 : 45, 99);
      if (r < 45)
         send(OP_ADD, pick_index(10), pick_index(10), pick_value(),
              POS_W'($urandom_range(0, 2047)));
      else if (r < 50)
         send(OP_W'($urandom_range(OP_UNKNOWN_LO, OP_UNKNOWN_HI)), IDX_W'($urandom()),
              IDX_W'($urandom()), $urandom(), POS_W'($urandom()));
      else if (r < 62)
         send(OP_PTR, IDX_W'($urandom()), IDX_W'($urandom()), $urandom(), pick_position());
      else if (r < 76)
         send(OP_ENTRY, IDX_W'($urandom()), IDX_W'($urandom()), $urandom(), pick_position());
      else
         send(OP_LOOKUP, pick_index(20), pick_index(20), $urandom(), POS_W'($urandom()));
   endtask

   function automatic logic [POS_W-1:0] pick_total();
      case ($urandom_range(0, 4))
         0: return POS_W'(1);
         1: return POS_W'(1024);
         2: return POS_W'($urandom_range(2, 4));
         default: return POS_W'($urandom_range(1, 1024));
      endcase
   endfunction

   initial begin
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      write_reg(CSR_ROW_TOTAL, 11'd1024);
      write_reg(CSR_COLUMN_TOTAL, 11'd1024);
      write_reg(CSR_ROW_MAJOR, 11'd1);

      // directed: not built, extremes, saturation, zero sum, unknown op
      send(OP_LOOKUP, 10'd0, 10'd0, 32'sd0, 11'd0);
      send(OP_PTR, 10'd0, 10'd0, 32'sd0, 11'd0);
      send(OP_ENTRY, 10'd0, 10'd0, 32'sd0, 11'd0);
      send(OP_ADD, 10'd1023, 10'd1023, -32'sd1, 11'd2047);
      send(OP_ADD, 10'd0, 10'd0, 32'sh7FFF_FFFF, 11'd0);
      send(OP_ADD, 10'd0, 10'd0, 32'sh7FFF_FFFF, 11'd0);
      send(OP_ADD, 10'd1, 10'd1, 32'sh8000_0000, 11'd0);
      send(OP_ADD, 10'd1, 10'd1, 32'sh8000_0000, 11'd0);
      send(OP_ADD, 10'd2, 10'd2, 32'sh0000_0005, 11'd0);
      send(OP_ADD, 10'd2, 10'd2, -32'sh0000_0005, 11'd0);
      send(OP_ADD, 10'd1, 10'd3, 32'sh0001_8000, 11'd0);
      send(OP_UNKNOWN_HI, 10'd1023, 10'd1023, -32'sd1, 11'd2047);
      send(OP_BUILD, 10'd0, 10'd0, 32'sd0, 11'd0);
      send(OP_PTR, 10'd0, 10'd0, 32'sd0, 11'd0);
      send(OP_PTR, 10'd0, 10'd0, 32'sd0, 11'd1024);
      send(OP_PTR, 10'd0, 10'd0, 32'sd0, 11'd2);
      send(OP_ENTRY, 10'd0, 10'd0, 32'sd0, 11'd0);
      send(OP_ENTRY, 10'd0, 10'd0, 32'sd0, 11'd3);
      send(OP_ENTRY, 10'd0, 10'd0, 32'sd0, 11'd1024);
      send(OP_LOOKUP, 10'd0, 10'd0, 32'sd0, 11'd0);
      send(OP_LOOKUP, 10'd1, 10'd1, 32'sd0, 11'd0);
      send(OP_LOOKUP, 10'd2, 10'd2, 32'sd0, 11'd0);
      send(OP_LOOKUP, 10'd1023, 10'd1023, 32'sd0, 11'd0);
      send(OP_LOOKUP, 10'd5, 10'd1000, 32'sd0, 11'd0);
      drain();

      // random phases under changing shape and mode
      for (int p = 0; p < PHASES; p++) begin
         write_reg(CSR_ROW_TOTAL, pick_total());
         write_reg(CSR_COLUMN_TOTAL, pick_total());
         write_reg(CSR_ROW_MAJOR, POS_W'(p[0]));
         quiet = (p == 1);
         repeat ($urandom_range(4, 8)) random_item(0);
         repeat (24) random_item(1);
         send(OP_BUILD, 10'd0, 10'd0, 32'sd0, 11'd0);
         repeat (12) random_item(0);
         drain();
      end

      // fill the store past full, then build
      quiet = 0;
      write_reg(CSR_ROW_TOTAL, 11'd1024);
      write_reg(CSR_COLUMN_TOTAL, 11'd1024);
      write_reg(CSR_ROW_MAJOR, 11'd1);
      while (adds_sent < STORE_DEPTH + 6)
         send(OP_ADD, pick_index(0), pick_index(0), pick_value(),
              POS_W'($urandom_range(0, 2047)));
      send(OP_BUILD, 10'd0, 10'd0, 32'sd0, 11'd0);
      repeat (10) random_item(0);
      drain();

      if (sb.errors == 0 && sb.awaited.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

/* sparse_triplet_to_compressed_builder.f */
+incdir+rtl
rtl/stcb_pkg.sv
rtl/stcb_ram.sv
rtl/stcb_ctrl.sv
rtl/stcb_dp.sv
rtl/sparse_triplet_to_compressed_builder.sv
test/sparse_triplet_to_compressed_builder_tb.sv
